[rtl/shv_pkg.sv]
// ----------------------------------------------------------------------------
// shv_pkg
// Shared types, the S-box table and the AES round helper for the
// 512-bit Feistel round function datapath.
// ----------------------------------------------------------------------------
package shv_pkg;

	localparam int NUM_CELLS = 4;
	localparam int STATE_W   = 128;
	// addends still to be applied: three round keys and the left words
	localparam int CARRY_W   = NUM_CELLS * STATE_W;

	typedef struct packed {
		logic [CARRY_W-1:0] carry;
		logic [STATE_W-1:0] st;
	} shv_item_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// SubBytes, ShiftRows, MixColumns; byte i lives at bits 8i+7:8i
	function automatic logic [STATE_W-1:0] aes_round(input logic [STATE_W-1:0] st);
		logic [7:0]         t [16];
		logic [7:0]         a0, a1, a2, a3;
		logic [STATE_W-1:0] res;
		res = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[4*c+r] = SBOX[st[8*(4*((c+r)%4)+r) +: 8]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c];
			a1 = t[4*c+1];
			a2 = t[4*c+2];
			a3 = t[4*c+3];
			res[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			res[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			res[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			res[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return res;
	endfunction

endpackage

[rtl/shv_round_cell.sv]
// ----------------------------------------------------------------------------
// shv_round_cell
// One AES round plus addend XOR, registered, with its own valid and stall.
// The lowest addend is consumed; the rest shift down toward the next cell.
// ----------------------------------------------------------------------------
module shv_round_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  shv_pkg::shv_item_t in_item,
	output logic              in_stall,
	output logic              out_valid,
	output shv_pkg::shv_item_t out_item,
	input  logic              out_stall
);

	logic              valid_q;
	shv_pkg::shv_item_t item_q;
	shv_pkg::shv_item_t item_d;

	// register can refill whenever it is empty or being drained this cycle
	assign in_stall = valid_q && out_stall;

	always_comb begin
		item_d.st    = shv_pkg::aes_round(in_item.st) ^ in_item.carry[shv_pkg::STATE_W-1:0];
		item_d.carry = {{shv_pkg::STATE_W{1'b0}},
			in_item.carry[shv_pkg::CARRY_W-1:shv_pkg::STATE_W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q <= item_d;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

[rtl/shavite512_round_function.sv]
// ----------------------------------------------------------------------------
// shavite512_round_function
// SHAvite-3 512-bit Feistel round function as a chain of AES round cells.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while in_stall is low and passes it
// through a chain of four registered AES round cells in a row. Each cell
// holds one transaction and applies SubBytes, ShiftRows, MixColumns and then
// the next 128-bit addend; the pending round keys and the left words ride
// down the chain with the state, the left words being the last cell's
// addend. Stall ripples back only through occupied cells, so up to four
// transactions sit in flight and the last cell doubles as the output
// register. No state survives between transactions.
module shavite512_round_function (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] left_lo,
	input  logic [63:0] left_hi,
	input  logic [63:0] right_lo,
	input  logic [63:0] right_hi,
	input  logic [63:0] key_pair_0,
	input  logic [63:0] key_pair_1,
	input  logic [63:0] key_pair_2,
	input  logic [63:0] key_pair_3,
	input  logic [63:0] key_pair_4,
	input  logic [63:0] key_pair_5,
	input  logic [63:0] key_pair_6,
	input  logic [63:0] key_pair_7,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] new_left_0,
	output logic [31:0] new_left_1,
	output logic [31:0] new_left_2,
	output logic [31:0] new_left_3
);

	logic               valid_c [shv_pkg::NUM_CELLS+1];
	logic               stall_c [shv_pkg::NUM_CELLS+1];
	shv_pkg::shv_item_t item_c  [shv_pkg::NUM_CELLS+1];

	always_comb begin
		item_c[0].st    = {right_hi, right_lo} ^ {key_pair_1, key_pair_0};
		item_c[0].carry = {left_hi, left_lo, key_pair_7, key_pair_6,
			key_pair_5, key_pair_4, key_pair_3, key_pair_2};
	end

	assign valid_c[0] = in_valid;
	assign in_stall   = stall_c[0];

	for (genvar i = 0; i < shv_pkg::NUM_CELLS; i++) begin : g_cell
		shv_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_item   (item_c[i]),
			.in_stall  (stall_c[i]),
			.out_valid (valid_c[i+1]),
			.out_item  (item_c[i+1]),
			.out_stall (stall_c[i+1])
		);
	end

	assign stall_c[shv_pkg::NUM_CELLS] = out_stall;
	assign out_valid  = valid_c[shv_pkg::NUM_CELLS];
	assign new_left_0 = item_c[shv_pkg::NUM_CELLS].st[31:0];
	assign new_left_1 = item_c[shv_pkg::NUM_CELLS].st[63:32];
	assign new_left_2 = item_c[shv_pkg::NUM_CELLS].st[95:64];
	assign new_left_3 = item_c[shv_pkg::NUM_CELLS].st[127:96];

endmodule

[rtl/shv_checker.sv]
// ----------------------------------------------------------------------------
// shv_checker
// Port-level checks for the round function: flow, latency and output hold.
// ----------------------------------------------------------------------------
module shv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] new_left_0,
	input logic [31:0] new_left_3
);

	// input backs up only when the whole chain is full behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled output");

	// with the output draining, an accepted transaction reaches the output through all four cells
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
		|=> out_valid)
		else $error("result missing four cycles after accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(new_left_0) && $stable(new_left_3)))
		else $error("stalled output payload changed");

endmodule

bind shavite512_round_function shv_checker u_shv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.new_left_0 (new_left_0),
	.new_left_3 (new_left_3)
);
